/* rtl/bfa_pkg.sv */
// Package for the bitmap first-fit allocator.
// Pool geometry, command and status codes, memory port structs.
// No dependencies.
package bfa_pkg;

  localparam int POOL_ENTRIES = 64;

  // Bitmap storage: one memory word holds WORD_BITS used bits.
  localparam int WORD_BITS = 16;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int NUM_WORDS = (POOL_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int IDX_W     = WADDR_W + BIT_W;

  // Field widths.
  localparam int CMD_W     = 2;
  localparam int ENTRY_W   = 8;
  localparam int RESULT_W  = 6;
  localparam int STATUS_W  = 2;
  localparam int RANGE_W   = ($clog2(POOL_ENTRIES + 1) > ENTRY_W) ?
                             $clog2(POOL_ENTRIES + 1) : ENTRY_W;
  localparam logic [RANGE_W-1:0] POOL_LIMIT = RANGE_W'(POOL_ENTRIES);

  // Valid entry bits of the last word; the other words are fully populated.
  localparam int LAST_REM = POOL_ENTRIES % WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_MASK =
    (LAST_REM == 0) ? {WORD_BITS{1'b1}} : WORD_BITS'((1 << LAST_REM) - 1);
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic               en;
    logic [WADDR_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic                 en;
    logic [WADDR_W-1:0]   addr;
    logic [WORD_BITS-1:0] data;
  } mem_wr_t;

endpackage

/* rtl/bitmap_first_fit_allocator_unit.sv */
// Bitmap first-fit allocator. One used bit per pool entry, held in a 16-bit-wide
// word memory with registered read data; all entries are free after reset.
// One transaction is handled at a time: a query or free passes through accept,
// read, check/write back and output; an out-of-range or unused command goes from
// accept straight to output; an allocate repeats read and check for each bitmap
// word scanned, up to all 4 words of the 64-entry pool, before output; the
// word-by-word read of the bitmap memory sets the allocate time.
// Depends on bfa_pkg, bfa_bitmap_mem, bfa_find_free.
module bitmap_first_fit_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] cmd, [9:2] entry_index, [15:10] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [5:0] result_index, [6] is_used, [8:7] status
);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_CHK, S_OUT} state_t;

  state_t                          state_r, state_nxt;
  logic [bfa_pkg::CMD_W-1:0]       cmd_r, cmd_nxt;
  logic [bfa_pkg::ENTRY_W-1:0]     ent_r, ent_nxt;
  logic [bfa_pkg::WADDR_W-1:0]     word_r, word_nxt;
  logic [bfa_pkg::RESULT_W-1:0]    res_idx_r, res_idx_nxt;
  logic                            res_used_r, res_used_nxt;
  logic [bfa_pkg::STATUS_W-1:0]    res_status_r, res_status_nxt;

  logic [bfa_pkg::CMD_W-1:0]       in_cmd;
  logic [bfa_pkg::ENTRY_W-1:0]     in_ent;
  logic                            in_oor;

  bfa_pkg::mem_rd_t                mem_rd;
  bfa_pkg::mem_wr_t                mem_wr;
  logic [bfa_pkg::WORD_BITS-1:0]   rd_data;
  logic [bfa_pkg::WORD_BITS-1:0]   scan_word;
  logic                            ff_found;
  logic [bfa_pkg::WORD_BITS-1:0]   ff_onehot;
  logic [bfa_pkg::BIT_W-1:0]       ff_pos;
  logic [bfa_pkg::BIT_W-1:0]       bit_sel;

  assign in_cmd  = in_tdata[1:0];
  assign in_ent  = in_tdata[9:2];
  assign in_oor  = bfa_pkg::RANGE_W'(in_ent) >= bfa_pkg::POOL_LIMIT;
  assign bit_sel = ent_r[bfa_pkg::BIT_W-1:0];

  // entries past the pool end in the last word look used to the search
  assign scan_word = (word_r == bfa_pkg::LAST_WORD) ? (rd_data | ~bfa_pkg::LAST_MASK)
                                                    : rd_data;

  bfa_bitmap_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd      (mem_rd),
    .wr      (mem_wr),
    .rd_data (rd_data)
  );

  bfa_find_free u_find (
    .word   (scan_word),
    .found  (ff_found),
    .onehot (ff_onehot),
    .pos    (ff_pos)
  );

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    ent_nxt        = ent_r;
    word_nxt       = word_r;
    res_idx_nxt    = res_idx_r;
    res_used_nxt   = res_used_r;
    res_status_nxt = res_status_r;
    mem_rd         = '0;
    mem_wr         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt        = in_cmd;
          ent_nxt        = in_ent;
          word_nxt       = (in_cmd == bfa_pkg::CMD_ALLOC) ? '0 :
                           bfa_pkg::WADDR_W'(in_ent >> bfa_pkg::BIT_W);
          res_idx_nxt    = '0;
          res_used_nxt   = 1'b0;
          res_status_nxt = bfa_pkg::ST_OK;
          if ((in_cmd == bfa_pkg::CMD_QUERY || in_cmd == bfa_pkg::CMD_FREE) && in_oor) begin
            res_status_nxt = bfa_pkg::ST_RANGE;
            state_nxt      = S_OUT;
          end else if (in_cmd == bfa_pkg::CMD_QUERY || in_cmd == bfa_pkg::CMD_FREE ||
                       in_cmd == bfa_pkg::CMD_ALLOC) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end

      S_RD: begin
        mem_rd.en   = 1'b1;
        mem_rd.addr = word_r;
        state_nxt   = S_CHK;
      end

      S_CHK: begin
        state_nxt = S_OUT;
        priority case (cmd_r)
          bfa_pkg::CMD_QUERY: begin
            res_used_nxt = rd_data[bit_sel];
          end
          bfa_pkg::CMD_FREE: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = word_r;
            mem_wr.data = rd_data & ~(bfa_pkg::WORD_BITS'(1) << bit_sel);
          end
          bfa_pkg::CMD_ALLOC: begin
            if (ff_found) begin
              mem_wr.en    = 1'b1;
              mem_wr.addr  = word_r;
              mem_wr.data  = rd_data | ff_onehot;
              res_idx_nxt  = bfa_pkg::RESULT_W'({word_r, ff_pos});
              res_used_nxt = 1'b1;
            end else if (word_r == bfa_pkg::LAST_WORD) begin
              res_status_nxt = bfa_pkg::ST_FULL;
            end else begin
              word_nxt  = bfa_pkg::WADDR_W'(word_r + 1'b1);
              state_nxt = S_RD;
            end
          end
          default: begin
          end
        endcase
      end

      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cmd_r        <= cmd_nxt;
    ent_r        <= ent_nxt;
    word_r       <= word_nxt;
    res_idx_r    <= res_idx_nxt;
    res_used_r   <= res_used_nxt;
    res_status_r <= res_status_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {7'd0, res_status_r, res_used_r, res_idx_r};

  // one transaction in flight: never accepting while a result is shown
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while result pending");

  a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_status_r == bfa_pkg::ST_FULL) |-> (!res_used_r && res_idx_r == '0))
    else $error("pool-full result carries a grant");

  a_write_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr.en |-> (cmd_r == bfa_pkg::CMD_FREE || cmd_r == bfa_pkg::CMD_ALLOC))
    else $error("bitmap written by a query");

  a_read_then_check: assert property (@(posedge clk) disable iff (!rst_n)
    mem_rd.en |=> (state_r == S_CHK))
    else $error("read data not consumed");

endmodule

/* rtl/bfa_bitmap_mem.sv */
// Bitmap word memory: one write port, one read port, registered read data.
// Per-word valid flops make unwritten words read as all free after reset.
// Depends on bfa_pkg.
module bfa_bitmap_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bfa_pkg::mem_rd_t              rd,
  input  bfa_pkg::mem_wr_t              wr,
  output logic [bfa_pkg::WORD_BITS-1:0] rd_data
);

  logic [bfa_pkg::WORD_BITS-1:0] mem [bfa_pkg::NUM_WORDS];
  logic [bfa_pkg::NUM_WORDS-1:0] valid_r;
  logic [bfa_pkg::WORD_BITS-1:0] rd_data_r;
  logic                          rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_vld_r <= valid_r[rd.addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

/* rtl/bfa_find_free.sv */
// Lowest-zero finder over one bitmap word.
// Returns a one-hot of the lowest free bit and its encoded position.
// Depends on bfa_pkg.
module bfa_find_free (
  input  logic [bfa_pkg::WORD_BITS-1:0] word,
  output logic                          found,
  output logic [bfa_pkg::WORD_BITS-1:0] onehot,
  output logic [bfa_pkg::BIT_W-1:0]     pos
);

  // ~w & (w+1) isolates the lowest zero bit
  assign onehot = ~word & (word + 1'b1);
  assign found  = |(~word);

  always_comb begin
    pos = '0;
    for (int k = 0; k < bfa_pkg::BIT_W; k++) begin
      for (int i = 0; i < bfa_pkg::WORD_BITS; i++) begin
        if (((i >> k) & 1) == 1) begin
          pos[k] = pos[k] | onehot[i];
        end
      end
    end
  end

endmodule
